/* hdl/detection_peak_suppression_2d_assert.svh */
// Assertion macros for the peak suppression block.
// Used by the top level only; no other dependencies.
`ifndef DETECTION_PEAK_SUPPRESSION_2D_ASSERT_SVH
`define DETECTION_PEAK_SUPPRESSION_2D_ASSERT_SVH
// implication check under clock and async reset
`define DPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dps check failed");
// next-cycle implication check
`define DPS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dps check failed");
`endif

/* hdl/dps_pkg.sv */
// Shared types and constants for the peak suppression block.
// No dependencies.
package dps_pkg;
	localparam int MAX_ROWS  = 128;
	localparam int MAX_COLS  = 1024;
	localparam int MAX_PICKS = 16;
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ADDR_W = ROW_W + COL_W;
	localparam int CELLS  = MAX_ROWS * MAX_COLS;
	localparam int CNT_W  = ADDR_W + 1;
	localparam int PICK_W = $clog2(MAX_PICKS + 1);
	localparam int PIX_W  = (MAX_PICKS > 1) ? $clog2(MAX_PICKS) : 1;
	localparam int PWR_W  = 32;

	localparam logic [2:0] REG_ROWS  = 3'd0;
	localparam logic [2:0] REG_COLS  = 3'd1;
	localparam logic [2:0] REG_DGAP  = 3'd2;
	localparam logic [2:0] REG_RGAP  = 3'd3;
	localparam logic [2:0] REG_PICKS = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic load;        // accept cell
		logic scan_start;  // begin scan pass
		logic pick_save;   // commit best to pick list
		logic cov_start;   // begin cover pass
		logic clr_start;
		logic out_load;    // load result register
		logic map_done;    // clear load position
	} dps_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_end;
		logic have;
		logic cov_end;
		logic clr_end;
		logic picks_full;
		logic last_out;
	} dps_sts_t;
endpackage

/* hdl/dps_ram.sv */
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
module dps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

/* hdl/dps_datapath.sv */
// Datapath: cell store, cover map, scan/compare, cover sweep, pick list.
// Uses dps_pkg and dps_ram.
module dps_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dps_pkg::dps_cmd_t          cmd,
	output dps_pkg::dps_sts_t          sts,
	input  logic [dps_pkg::PWR_W-1:0]  cell_power,
	input  logic                       cell_detected,
	input  logic [7:0]                 rows_in_use,
	input  logic [10:0]                cols_in_use,
	input  logic [3:0]                 doppler_gap,
	input  logic [3:0]                 range_gap,
	input  logic [4:0]                 max_picks,
	output logic [50:0]                res
);
	localparam int AW = dps_pkg::ADDR_W;
	localparam int RW = dps_pkg::ROW_W;
	localparam int CW = dps_pkg::COL_W;

	// clamped geometry
	logic [RW:0] rows;
	logic [CW:0] cols;
	logic [dps_pkg::PICK_W-1:0] kmax;
	always_comb begin
		if (rows_in_use == 8'd0) rows = (RW+1)'(1);
		else if (9'(rows_in_use) > 9'(dps_pkg::MAX_ROWS)) rows = (RW+1)'(dps_pkg::MAX_ROWS);
		else rows = (RW+1)'(rows_in_use);
		if (cols_in_use == 11'd0) cols = (CW+1)'(1);
		else if (12'(cols_in_use) > 12'(dps_pkg::MAX_COLS)) cols = (CW+1)'(dps_pkg::MAX_COLS);
		else cols = (CW+1)'(cols_in_use);
		if (max_picks == 5'd0) kmax = dps_pkg::PICK_W'(1);
		else if (7'(max_picks) > 7'(dps_pkg::MAX_PICKS)) kmax = dps_pkg::PICK_W'(dps_pkg::MAX_PICKS);
		else kmax = dps_pkg::PICK_W'(max_picks);
	end
	logic [dps_pkg::CNT_W-1:0] cap;
	assign cap = dps_pkg::CNT_W'(rows) * dps_pkg::CNT_W'(cols);

	// load position; cells are stored in arrival order
	logic [dps_pkg::CNT_W-1:0] pos_q;
	logic full;
	assign full = (pos_q >= cap);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.map_done) begin
			pos_q <= '0;
		end else if (cmd.load && !full) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	// power store: address = arrival index
	logic st_we;
	logic [AW-1:0] st_wa, st_ra, cv_ra;
	logic [32:0] st_rd;
	assign st_we = cmd.load && !full;
	assign st_wa = pos_q[AW-1:0];
	dps_ram #(.WIDTH(33), .DEPTH(dps_pkg::CELLS)) u_store (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata({cell_detected, cell_power}),
		.raddr(st_ra), .rdata(st_rd)
	);

	// cover map: address = row*MAX_COLS + col
	logic cv_we, cv_wd;
	logic [AW-1:0] cv_wa;
	logic [0:0] cv_rd;
	dps_ram #(.WIDTH(1), .DEPTH(dps_pkg::CELLS)) u_cover (
		.clk(clk), .we(cv_we), .waddr(cv_wa), .wdata(cv_wd),
		.raddr(cv_ra), .rdata(cv_rd)
	);

	// scan: raster cursor, one cell a cycle, compare in the cycle after the read address
	logic [RW:0] srow_q;
	logic [CW:0] scol_q;
	logic [dps_pkg::CNT_W-1:0] sidx_q;
	logic srun_q, sv_s1;
	logic [RW:0] vrow_s1;
	logic [CW:0] vcol_s1;
	logic have_q;
	logic [RW:0] brow_q;
	logic [CW:0] bcol_q;
	logic [31:0] bpwr_q;
	logic [dps_pkg::CNT_W-1:0] limit;
	assign limit = (pos_q < cap) ? pos_q : cap;
	assign st_ra = sidx_q[AW-1:0];
	assign cv_ra = {srow_q[RW-1:0], scol_q[CW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srun_q <= 1'b0; sv_s1 <= 1'b0; have_q <= 1'b0;
			srow_q <= '0; scol_q <= '0; sidx_q <= '0;
		end else if (cmd.scan_start) begin
			srun_q <= (limit != '0); sv_s1 <= 1'b0; have_q <= 1'b0;
			srow_q <= '0; scol_q <= '0; sidx_q <= '0;
		end else begin
			sv_s1 <= srun_q;
			if (srun_q) begin
				vrow_s1 <= srow_q; vcol_s1 <= scol_q;
				sidx_q <= sidx_q + 1'b1;
				if (sidx_q + 1'b1 >= limit) srun_q <= 1'b0;
				if (scol_q + 1'b1 >= cols) begin
					scol_q <= '0; srow_q <= srow_q + 1'b1;
				end else begin
					scol_q <= scol_q + 1'b1;
				end
			end
			if (sv_s1 && st_rd[32] && !cv_rd[0] && (!have_q || st_rd[31:0] > bpwr_q)) begin
				have_q <= 1'b1;
				brow_q <= vrow_s1; bcol_q <= vcol_s1; bpwr_q <= st_rd[31:0];
			end
		end
	end
	assign sts.scan_end = !srun_q && !sv_s1 && !cmd.scan_start;
	assign sts.have = have_q;

	// cover window sweep, also the per-map clear sweep
	logic [RW:0] r1, crow_q, cr1_q;
	logic [CW:0] c1, ccol_q, cc0_q, cc1_q;
	logic crun_q, clr_q;
	logic [RW+1:0] rsum;
	logic [CW+1:0] csum;
	assign rsum = (RW+2)'(brow_q) + (RW+2)'(doppler_gap);
	assign csum = (CW+2)'(bcol_q) + (CW+2)'(range_gap);
	assign r1 = (rsum > (RW+2)'(rows - 1'b1)) ? rows - 1'b1 : rsum[RW:0];
	assign c1 = (csum > (CW+2)'(cols - 1'b1)) ? cols - 1'b1 : csum[CW:0];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crun_q <= 1'b0; clr_q <= 1'b0;
		end else if (cmd.cov_start || cmd.clr_start) begin
			crun_q <= 1'b1; clr_q <= cmd.clr_start;
			if (cmd.clr_start) begin
				crow_q <= '0; ccol_q <= '0; cc0_q <= '0;
				cr1_q <= rows - 1'b1; cc1_q <= cols - 1'b1;
			end else begin
				crow_q <= (brow_q > (RW+1)'(doppler_gap)) ? brow_q - (RW+1)'(doppler_gap) : '0;
				cc0_q  <= (bcol_q > (CW+1)'(range_gap)) ? bcol_q - (CW+1)'(range_gap) : '0;
				ccol_q <= (bcol_q > (CW+1)'(range_gap)) ? bcol_q - (CW+1)'(range_gap) : '0;
				cr1_q <= r1; cc1_q <= c1;
			end
		end else if (crun_q) begin
			if (ccol_q == cc1_q) begin
				ccol_q <= cc0_q;
				if (crow_q == cr1_q) crun_q <= 1'b0;
				else crow_q <= crow_q + 1'b1;
			end else begin
				ccol_q <= ccol_q + 1'b1;
			end
		end
	end
	assign cv_we = crun_q;
	assign cv_wd = !clr_q;
	assign cv_wa = {crow_q[RW-1:0], ccol_q[CW-1:0]};
	assign sts.cov_end = !crun_q && !cmd.cov_start && !cmd.clr_start;
	assign sts.clr_end = sts.cov_end;

	// pick list (small, flops), output cursor
	logic [48:0] picks_q [dps_pkg::MAX_PICKS];
	logic [dps_pkg::PICK_W-1:0] pcnt_q, ocnt_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= '0; ocnt_q <= '0;
		end else begin
			if (cmd.clr_start) begin
				pcnt_q <= '0; ocnt_q <= '0;
			end else if (cmd.pick_save) begin
				picks_q[pcnt_q[dps_pkg::PIX_W-1:0]] <=
					{bpwr_q, bcol_q[CW-1:0], brow_q[RW-1:0]};
				pcnt_q <= pcnt_q + 1'b1;
			end
			if (cmd.out_load) ocnt_q <= ocnt_q + 1'b1;
		end
	end
	assign sts.picks_full = (pcnt_q >= kmax);
	logic [48:0] pe;
	logic lastp;
	assign pe = picks_q[ocnt_q[dps_pkg::PIX_W-1:0]];
	assign lastp = (pcnt_q == '0) || (ocnt_q + 1'b1 >= pcnt_q);
	assign sts.last_out = lastp;
	// res: {last_pick, found, power, range, doppler}
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (pcnt_q == '0) res <= {1'b1, 50'd0};
			else res <= {lastp, 1'b1, pe[48:17], 10'(pe[16:RW]), 7'(pe[RW-1:0])};
		end
	end
endmodule

/* hdl/dps_ctrl.sv */
// Controller state machine for the peak suppression block.
// Uses dps_pkg; drives the datapath by command struct.
module dps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              in_last,
	input  logic              out_fire,
	input  dps_pkg::dps_sts_t sts,
	output dps_pkg::dps_cmd_t cmd,
	output logic              in_ready,
	output logic              out_valid
);
	typedef enum logic [2:0] {
		S_LOAD, S_CLR, S_SCAN, S_DECIDE, S_COVER, S_EMIT, S_WAIT
	} state_t;
	state_t state_q;
	logic start_q;
	logic start_d;

	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		cmd.clr_start  = (state_q == S_CLR) && start_q;
		cmd.scan_start = (state_q == S_SCAN) && start_q;
		cmd.cov_start  = (state_q == S_COVER) && start_q;
		cmd.pick_save  = (state_q == S_DECIDE) && sts.have && !sts.picks_full;
		cmd.out_load   = (state_q == S_EMIT) && (!out_valid || out_fire);
		cmd.map_done   = cmd.out_load && sts.last_out;
	end
	assign in_ready = (state_q == S_LOAD);

	// one-cycle start pulse on entry to a sweep or scan
	always_comb begin
		case (state_q)
			S_LOAD:   start_d = in_fire && in_last;
			S_CLR:    start_d = !start_q && sts.clr_end;
			S_DECIDE: start_d = sts.have && !sts.picks_full;
			S_COVER:  start_d = !start_q && sts.cov_end;
			default:  start_d = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD; start_q <= 1'b0; out_valid <= 1'b0;
		end else begin
			start_q <= start_d;
			out_valid <= cmd.out_load || (out_valid && !out_fire);
			case (state_q)
				S_LOAD: if (in_fire && in_last) begin
					state_q <= S_CLR;
				end
				S_CLR: if (!start_q && sts.clr_end) begin
					state_q <= S_SCAN;
				end
				S_SCAN: if (!start_q && sts.scan_end) begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (sts.picks_full || !sts.have) state_q <= S_EMIT;
					else state_q <= S_COVER;
				end
				S_COVER: if (!start_q && sts.cov_end) begin
					state_q <= S_SCAN;
				end
				S_EMIT: if (cmd.out_load && sts.last_out) begin
					state_q <= S_WAIT;
				end
				S_WAIT: if (out_fire || !out_valid) state_q <= S_LOAD;
				default: state_q <= S_LOAD;
			endcase
		end
	end
endmodule

/* hdl/detection_peak_suppression_2d.sv */
// Greedy 2-D peak suppression over a range-Doppler map. Load: one cell item per cycle
// while s_tvalid is high. After the last cell: a cover-map clear of rows*cols cells, then
// per pick a scan of the N loaded cells, a decide step and a sweep of the clipped cover
// window of at most (2*dgap+1)*(2*rgap+1) cells; a final scan and decide close selection.
// Results then follow one per cycle while m_tready is high; input reopens once the last
// is taken. Async reset clears control, counters, load position; cell store undefined.
module detection_peak_suppression_2d (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // cell_power[31:0], cell_detected[32], pad
	input  logic        s_tlast,   // last_cell
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // row_idx[6:0], col_idx[16:7], peak_power[48:17], found[49]
	output logic        m_tlast,   // last_pick
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data
);
	// configuration registers
	logic [7:0]  rows_q;
	logic [10:0] cols_q;
	logic [3:0]  dgap_q, rgap_q;
	logic [4:0]  picks_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 8'd128; cols_q <= 11'd1024; dgap_q <= 4'd1;
			rgap_q <= 4'd2; picks_q <= 5'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				dps_pkg::REG_ROWS:  rows_q  <= cfg_data[7:0];
				dps_pkg::REG_COLS:  cols_q  <= cfg_data;
				dps_pkg::REG_DGAP:  dgap_q  <= cfg_data[3:0];
				dps_pkg::REG_RGAP:  rgap_q  <= cfg_data[3:0];
				dps_pkg::REG_PICKS: picks_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	dps_pkg::dps_cmd_t cmd;
	dps_pkg::dps_sts_t sts;
	logic in_fire, out_fire;
	logic [50:0] res;
	assign in_fire  = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	dps_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_last(s_tlast),
		.out_fire(out_fire), .sts(sts), .cmd(cmd), .in_ready(s_tready),
		.out_valid(m_tvalid)
	);

	dps_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cell_power(s_tdata[31:0]), .cell_detected(s_tdata[32]),
		.rows_in_use(rows_q), .cols_in_use(cols_q), .doppler_gap(dgap_q),
		.range_gap(rgap_q), .max_picks(picks_q), .res(res)
	);

	assign m_tdata = {6'd0, res[49:0]};
	assign m_tlast = res[50];

	`include "detection_peak_suppression_2d_assert.svh"
	// no input taken while results are pending
	`DPS_ASSERT_IMP(a_no_in_while_out, m_tvalid, !s_tready)
	// the empty-map marker is always the only, hence last, result
	`DPS_ASSERT_IMP(a_empty_is_last, m_tvalid && !m_tdata[49], m_tlast)
	// last cell hands over to selection
	`DPS_ASSERT_NXT(a_last_stops_in, in_fire && s_tlast, !s_tready)
endmodule
